// File: sv/deadline_timer_scheduler_top_assert.svh
// Assertion macros for the deadline timer scheduler.
// Depends on nothing; included by the top level.
`ifndef DEADLINE_TIMER_SCHEDULER_TOP_ASSERT_SVH
`define DEADLINE_TIMER_SCHEDULER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define DTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DTS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTS_ASSERT(label, clk, rst, prop, msg)
`define DTS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: sv/dts_pkg.sv
// Shared types and constants for the deadline timer scheduler.
// Depends on nothing.
package dts_pkg;
  localparam int NUM_SLOTS = 16;
  localparam int MAX_FIRES = 16;
  localparam int SLOT_W = 4;
  localparam int FIRE_W = 6;
  localparam logic [15:0] MIN_RESET = 16'd50;
  localparam logic [23:0] MAX_RESET = 24'd50000;
  localparam logic [31:0] CMP_RESET = 32'd1000;

  typedef enum logic [1:0] {
    CMD_ARM_ABS = 2'd0,
    CMD_ARM_DELAY = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_MIN = 1'b0,
    CFG_MAX = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAPTURE,
    ST_SCAN,
    ST_DECIDE,
    ST_FIRE,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_step;
    logic fire;
    logic compare;
    logic emit_fire;
    logic emit_status;
    logic set_limit;
  } ctrl_t;

  typedef struct packed {
    logic is_tick;
    logic is_arm;
    logic scan_done;
    logic due;
    logic arm_is_best;
    logic cap_reached;
    logic out_busy;
  } stat_t;
endpackage

// File: sv/dts_if.sv
// Valid/ready channel interfaces for the deadline timer scheduler.
// Depends on nothing.
interface dts_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] command;
  logic [3:0] slot;
  logic [63:0] time_value;
  logic [31:0] period;
  logic [31:0] counter_now;
  modport source (output valid, command, slot, time_value, period, counter_now, input ready);
  modport sink (input valid, command, slot, time_value, period, counter_now, output ready);
endinterface

interface dts_out_if (input logic clk);
  logic valid;
  logic ready;
  logic kind;
  logic [3:0] fired_slot;
  logic [31:0] compare_value;
  logic compare_changed;
  logic [63:0] now_time;
  logic fire_limit_hit;
  logic last;
  modport source (output valid, kind, fired_slot, compare_value, compare_changed, now_time,
                  fire_limit_hit, last, input ready);
  modport sink (input valid, kind, fired_slot, compare_value, compare_changed, now_time,
                fire_limit_hit, last, output ready);
endinterface

interface dts_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/dts_ctrl.sv
// Controller state machine for the deadline timer scheduler.
// Depends on dts_pkg.
module dts_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  dts_pkg::stat_t stat,
  output dts_pkg::ctrl_t ctrl,
  output dts_pkg::state_t state_q
);
  dts_pkg::state_t state, state_next;
  assign state_q = state;

  always_ff @(posedge clk) begin
    if (rst) state <= dts_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    in_ready = 1'b0;
    unique case (state)
      dts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next = dts_pkg::ST_CAPTURE;
        end
      end
      dts_pkg::ST_CAPTURE: begin
        ctrl.scan_start = 1'b1;
        state_next = dts_pkg::ST_SCAN;
        if (!stat.is_tick && !stat.is_arm) state_next = dts_pkg::ST_STATUS;
      end
      dts_pkg::ST_SCAN: begin
        ctrl.scan_step = 1'b1;
        if (stat.scan_done) state_next = dts_pkg::ST_DECIDE;
      end
      dts_pkg::ST_DECIDE: begin
        if (stat.is_tick && stat.due && !stat.cap_reached) begin
          state_next = dts_pkg::ST_FIRE;
        end else begin
          ctrl.set_limit = stat.is_tick && stat.due;
          if (stat.is_tick || stat.arm_is_best) ctrl.compare = 1'b1;
          state_next = dts_pkg::ST_STATUS;
        end
      end
      dts_pkg::ST_FIRE: begin
        if (!stat.out_busy) begin
          ctrl.emit_fire = 1'b1;
          ctrl.fire = 1'b1;
          ctrl.scan_start = 1'b1;
          state_next = dts_pkg::ST_SCAN;
        end
      end
      dts_pkg::ST_STATUS: begin
        if (!stat.out_busy) begin
          ctrl.emit_status = 1'b1;
          state_next = dts_pkg::ST_IDLE;
        end
      end
      default: state_next = dts_pkg::ST_IDLE;
    endcase
  end
endmodule

// File: sv/dts_datapath.sv
// Datapath: slot table, time extension, earliest-deadline scan, compare and output register.
// Depends on dts_pkg.
module dts_datapath (
  input  logic clk,
  input  logic rst,
  input  dts_pkg::ctrl_t ctrl,
  output dts_pkg::stat_t stat,
  input  logic [1:0] command,
  input  logic [3:0] slot,
  input  logic [63:0] time_value,
  input  logic [31:0] period,
  input  logic [31:0] counter_now,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [31:0] cfg_data,
  output logic out_valid,
  input  logic out_ready,
  output logic kind,
  output logic [3:0] fired_slot,
  output logic [31:0] compare_value,
  output logic compare_changed,
  output logic [63:0] now_time,
  output logic fire_limit_hit,
  output logic last
);
  logic [63:0] slot_deadline [dts_pkg::NUM_SLOTS];
  logic [31:0] slot_period [dts_pkg::NUM_SLOTS];
  logic [dts_pkg::NUM_SLOTS-1:0] slot_armed;
  logic [31:0] time_base, previous_count, compare_reg;
  logic [15:0] min_interval;
  logic [23:0] max_interval;
  logic [1:0] cmd;
  logic [3:0] slot_q;
  logic [63:0] now;
  logic [dts_pkg::SLOT_W:0] scan_idx;
  logic best_found;
  logic [dts_pkg::SLOT_W-1:0] best_idx;
  logic [63:0] best_dl;
  logic [dts_pkg::FIRE_W-1:0] fires;
  logic limit, changed;
  logic [dts_pkg::SLOT_W-1:0] si;
  logic [63:0] now_next, soonest, target;

  assign si = scan_idx[dts_pkg::SLOT_W-1:0];
  assign now_next = {(counter_now < previous_count) ? time_base + 32'd1 : time_base,
                     counter_now};
  assign soonest = now + {48'd0, min_interval};

  always_comb begin
    target = now + {40'd0, max_interval};
    if (best_found) begin
      if (best_dl <= soonest) target = soonest;
      else if (best_dl < target) target = best_dl;
    end
  end

  assign stat.is_tick = (cmd == dts_pkg::CMD_TICK);
  assign stat.is_arm = (cmd == dts_pkg::CMD_ARM_ABS) || (cmd == dts_pkg::CMD_ARM_DELAY);
  assign stat.scan_done = (scan_idx == (dts_pkg::SLOT_W+1)'(dts_pkg::NUM_SLOTS));
  assign stat.due = best_found && (best_dl <= now);
  assign stat.arm_is_best = best_found && (best_idx == slot_q);
  assign stat.cap_reached = (fires == dts_pkg::FIRE_W'(dts_pkg::MAX_FIRES));
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_armed <= '0;
      time_base <= '0;
      previous_count <= '0;
      compare_reg <= dts_pkg::CMP_RESET;
      min_interval <= dts_pkg::MIN_RESET;
      max_interval <= dts_pkg::MAX_RESET;
      out_valid <= 1'b0;
      scan_idx <= '0;
      best_found <= 1'b0;
      fires <= '0;
      limit <= 1'b0;
      changed <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == dts_pkg::CFG_MIN) min_interval <= cfg_data[15:0];
        else max_interval <= cfg_data[23:0];
      end
      if (ctrl.emit_fire || ctrl.emit_status) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (ctrl.capture) begin
        time_base <= now_next[63:32];
        previous_count <= counter_now;
        now <= now_next;
        cmd <= command;
        slot_q <= slot;
        fires <= '0;
        limit <= 1'b0;
        changed <= 1'b0;
        if (command == dts_pkg::CMD_ARM_ABS || command == dts_pkg::CMD_ARM_DELAY) begin
          slot_deadline[slot] <= (command == dts_pkg::CMD_ARM_ABS) ? time_value
                                                                  : now_next + time_value;
          slot_period[slot] <= period;
          slot_armed[slot] <= 1'b1;
        end else if (command == dts_pkg::CMD_CANCEL) begin
          slot_armed[slot] <= 1'b0;
        end
      end
      if (ctrl.scan_start) begin
        scan_idx <= '0;
        best_found <= 1'b0;
      end else if (ctrl.scan_step && !stat.scan_done) begin
        scan_idx <= scan_idx + 1'b1;
        if (slot_armed[si] && (!best_found || slot_deadline[si] < best_dl)) begin
          best_found <= 1'b1;
          best_idx <= si;
          best_dl <= slot_deadline[si];
        end
      end
      if (ctrl.fire) begin
        fires <= fires + 1'b1;
        if (slot_period[best_idx] != 32'd0)
          slot_deadline[best_idx] <= best_dl + {32'd0, slot_period[best_idx]};
        else slot_armed[best_idx] <= 1'b0;
      end
      if (ctrl.set_limit) limit <= 1'b1;
      if (ctrl.compare) begin
        compare_reg <= target[31:0];
        changed <= 1'b1;
      end
      if (ctrl.emit_fire) begin
        kind <= 1'b0;
        fired_slot <= best_idx;
        compare_value <= '0;
        compare_changed <= 1'b0;
        now_time <= now;
        fire_limit_hit <= 1'b0;
        last <= 1'b0;
      end
      if (ctrl.emit_status) begin
        kind <= 1'b1;
        fired_slot <= '0;
        compare_value <= compare_reg;
        compare_changed <= changed;
        now_time <= now;
        fire_limit_hit <= limit;
        last <= 1'b1;
      end
    end
  end
endmodule

// File: sv/deadline_timer_scheduler_top.sv
// An arm or tick scans all 16 slots for the earliest deadline; a tick rescans after each firing.
// One request at a time; the next is accepted in the cycle after the status result is loaded into the output register.
// Results leave through a one-entry output register; ready stalls the controller.
// Synchronous active-high reset clears armed bits, time extension, compare (1000)
// and interval registers; slot deadlines and periods are not reset.
module deadline_timer_scheduler_top (
  input logic clk,
  input logic rst,
  dts_in_if.sink in_ch,
  dts_out_if.source out_ch,
  dts_cfg_if.sink cfg
);
`include "deadline_timer_scheduler_top_assert.svh"
  dts_pkg::ctrl_t ctrl;
  dts_pkg::stat_t stat;
  dts_pkg::state_t state;

  assign cfg.ready = 1'b1;

  dts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .stat(stat), .ctrl(ctrl), .state_q(state)
  );

  dts_datapath u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .command(in_ch.command), .slot(in_ch.slot), .time_value(in_ch.time_value),
    .period(in_ch.period), .counter_now(in_ch.counter_now),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .kind(out_ch.kind),
    .fired_slot(out_ch.fired_slot), .compare_value(out_ch.compare_value),
    .compare_changed(out_ch.compare_changed), .now_time(out_ch.now_time),
    .fire_limit_hit(out_ch.fire_limit_hit), .last(out_ch.last)
  );

  `DTS_ASSERT(a_ready_idle, clk, rst, in_ch.ready |-> state == dts_pkg::ST_IDLE, "ready busy")
  `DTS_ASSERT(a_last_kind, clk, rst, out_ch.valid |-> out_ch.last == out_ch.kind, "last/kind")
  `DTS_ASSERT(a_fire_tick, clk, rst, ctrl.fire |-> stat.is_tick && stat.due, "fire not due")
  `DTS_ASSERT_NR(a_emit_free, clk, (ctrl.emit_fire || ctrl.emit_status) |-> !stat.out_busy, "busy")
endmodule
